// File: rtl/mbps_pkg.sv
// Shared constants and types for the masked byte pattern scanner.
package mbps_pkg;

   localparam int SCAN_BYTES_DEF   = 4096;
   localparam int TAIL_BYTES_DEF   = 64;
   localparam int MAX_ELEMENTS_DEF = 64;

   localparam int BYTE_W   = 8;
   localparam int KIND_W   = 2;
   localparam int INDEX_W  = 6;
   localparam int LENGTH_W = 7;
   localparam int START_W  = 13;
   localparam int CAPPOS_W = 14;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 32;

   localparam logic [KIND_W-1:0] KIND_EXACT   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CAPTURE = 2'd2;

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_DATA = 1'b1;

   typedef struct packed {
      logic              step;
      logic              clear;
      logic              first_ok;
      logic [BYTE_W-1:0] data_byte;
   } mbps_step_type;

   typedef struct packed {
      logic hit;
      logic last;
      logic cap;
   } mbps_stat_type;

endpackage

// File: rtl/mbps_cell.sv
// One pattern element: stored byte and kind, partial match bit, settle chains.
module mbps_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          active,
   input  logic                          load_we,
   input  logic [mbps_pkg::BYTE_W-1:0]   load_byte,
   input  logic [mbps_pkg::KIND_W-1:0]   load_kind,
   input  mbps_pkg::mbps_step_type       ctrl,
   input  logic                          pm_prev,
   output logic                          pm_out,
   input  logic                          seen_in,
   output logic                          seen_out,
   input  logic                          after_in,
   output logic                          after_out,
   input  logic                          cap_seen_in,
   output logic                          cap_seen_out,
   output mbps_pkg::mbps_stat_type       stat
);
   import mbps_pkg::*;

   logic [BYTE_W-1:0] byte_ff;
   logic [KIND_W-1:0] kind_ff;
   logic              pm_ff, pm_in, pm_new;
   logic              seen_ff, after_ff, cap_seen_ff;
   logic              exact, capture, is_first, in_range, is_last, match;

   assign exact    = active && (kind_ff == KIND_EXACT);
   assign capture  = active && (kind_ff == KIND_CAPTURE);
   assign match    = (byte_ff == ctrl.data_byte);
   assign is_first = exact && !seen_ff;
   assign in_range = active && seen_ff && (exact || after_ff);
   assign is_last  = exact && !after_ff;

   always_comb begin
      pm_new = pm_ff;
      if (ctrl.step) begin
         if (is_first) begin
            pm_new = ctrl.first_ok && match;
         end else if (in_range) begin
            pm_new = pm_prev && (!exact || match);
         end
      end
      pm_in = ctrl.clear ? 1'b0 : pm_new;
   end

   assign pm_out       = pm_ff;
   assign seen_out     = seen_ff || exact;
   assign after_out    = after_ff || exact;
   assign cap_seen_out = cap_seen_ff || capture;

   assign stat.hit  = ctrl.step && is_last && pm_new;
   assign stat.last = is_last;
   assign stat.cap  = capture && !cap_seen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pm_ff       <= 1'b0;
         seen_ff     <= 1'b0;
         after_ff    <= 1'b0;
         cap_seen_ff <= 1'b0;
      end else begin
         pm_ff       <= pm_in;
         seen_ff     <= seen_in;
         after_ff    <= after_in;
         cap_seen_ff <= cap_seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_we) begin
         byte_ff <= load_byte;
         kind_ff <= load_kind;
      end
   end

endmodule

// File: rtl/masked_byte_pattern_scanner_core.sv
// Top level of the masked byte pattern scanner: cell row, position, result register.
//
// The req channel carries load items (tuser 0) that write one pattern element,
// and data items (tuser 1) that stream the bytes of a block, tlast on its final
// byte. csr_we writes pattern_length, the number of elements in use.
// Each data byte moves one step through a row of MAX_ELEMENTS cells that hold
// the partial matches, so data items follow back to back while req_tready is
// high. A result is registered with the byte that ends the search and shows
// in the next cycle: the matching byte, or the last byte of a block with no match.
// After a load item or a csr write, the row's exact/capture prefix and suffix
// chains resettle through one cell a cycle, so req_tready stays low until a
// settle counter runs out; the same wait follows reset.
// Reset clears the partial matches, position and pattern_length (to 1); the
// pattern must be loaded before use.
// A result waits in the output register while rsp_tready is low; req_tready
// stays high only while that register is free or being taken in the same cycle.
module masked_byte_pattern_scanner_core #(
   parameter int SCAN_BYTES   = mbps_pkg::SCAN_BYTES_DEF,
   parameter int TAIL_BYTES   = mbps_pkg::TAIL_BYTES_DEF,
   parameter int MAX_ELEMENTS = mbps_pkg::MAX_ELEMENTS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [mbps_pkg::LENGTH_W-1:0]     csr_wdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // elem_index[5:0], elem_byte[13:6], elem_kind[15:14], data_byte[23:16]
   input  logic [mbps_pkg::REQ_DATA_W-1:0]   req_tdata,
   // req_type[0]
   input  logic                              req_tuser,
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // found[0], match_start[13:1], capture_valid[14], capture_pos[28:15], zero[31:29]
   output logic [mbps_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import mbps_pkg::*;

   localparam int LIMIT = SCAN_BYTES + TAIL_BYTES;
   localparam int PW    = $clog2(LIMIT + 1);
   localparam int IW    = $clog2(MAX_ELEMENTS);
   localparam int SW    = PW + 10;
   localparam int CW    = $clog2(MAX_ELEMENTS + 3);
   localparam logic [CW-1:0] SETTLE = CW'(MAX_ELEMENTS + 2);

   logic [LENGTH_W-1:0] len_ff;
   logic [PW-1:0]       pos_ff, pos_in;
   logic                done_ff, done_in;
   logic [CW-1:0]       settle_ff, settle_in;
   logic [IW-1:0]       lastx_ff, lastx_in, cap_ff, cap_in;
   logic                has_cap_ff, has_cap_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                accept, is_data, is_load, in_win, hit;
   logic [INDEX_W-1:0]  elem_index;
   logic [BYTE_W-1:0]   elem_byte, data_byte;
   logic [KIND_W-1:0]   elem_kind;
   logic [SW-1:0]       start_full, cap_full;
   mbps_step_type       ctrl;

   logic [MAX_ELEMENTS-1:0] pm, seen, after, cap_seen, active, load_we;
   mbps_stat_type           stat [MAX_ELEMENTS];

   assign elem_index = req_tdata[5:0];
   assign elem_byte  = req_tdata[13:6];
   assign elem_kind  = req_tdata[15:14];
   assign data_byte  = req_tdata[23:16];

   assign req_tready = (settle_ff == '0) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign is_data    = accept && (req_tuser == REQ_DATA);
   assign is_load    = accept && (req_tuser == REQ_LOAD);
   assign in_win     = pos_ff < PW'(LIMIT);

   assign ctrl.step      = is_data && !done_ff && in_win;
   assign ctrl.clear     = is_data && (req_tlast || (!done_ff && !in_win));
   assign ctrl.first_ok  = pos_ff < PW'(SCAN_BYTES);
   assign ctrl.data_byte = data_byte;

   genvar g;
   generate
      for (g = 0; g < MAX_ELEMENTS; g++) begin : g_cell
         assign active[g]  = 32'(len_ff) > g;
         assign load_we[g] = is_load && (32'(elem_index) == g);

         mbps_cell u_cell (
            .clock        (clock),
            .reset        (reset),
            .active       (active[g]),
            .load_we      (load_we[g]),
            .load_byte    (elem_byte),
            .load_kind    (elem_kind),
            .ctrl         (ctrl),
            .pm_prev      ((g == 0) ? 1'b0 : pm[(g == 0) ? 0 : g - 1]),
            .pm_out       (pm[g]),
            .seen_in      ((g == 0) ? 1'b0 : seen[(g == 0) ? 0 : g - 1]),
            .seen_out     (seen[g]),
            .after_in     ((g == MAX_ELEMENTS - 1) ? 1'b0
                           : after[(g == MAX_ELEMENTS - 1) ? g : g + 1]),
            .after_out    (after[g]),
            .cap_seen_in  ((g == 0) ? 1'b0 : cap_seen[(g == 0) ? 0 : g - 1]),
            .cap_seen_out (cap_seen[g]),
            .stat         (stat[g])
         );
      end
   endgenerate

   always_comb begin
      hit        = 1'b0;
      lastx_in   = '0;
      cap_in     = '0;
      has_cap_in = 1'b0;
      for (int n = 0; n < MAX_ELEMENTS; n++) begin
         hit        = hit | stat[n].hit;
         lastx_in   = lastx_in | (stat[n].last ? IW'(n) : '0);
         cap_in     = cap_in | (stat[n].cap ? IW'(n) : '0);
         has_cap_in = has_cap_in | stat[n].cap;
      end
   end

   assign start_full = SW'(pos_ff) - SW'(lastx_ff);
   assign cap_full   = start_full + SW'(cap_ff);

   always_comb begin
      settle_in    = (settle_ff != '0) ? settle_ff - CW'(1) : settle_ff;
      if (csr_we || is_load) begin
         settle_in = SETTLE;
      end
      pos_in  = pos_ff;
      done_in = done_ff;
      if (ctrl.step) begin
         pos_in = pos_ff + PW'(1);
      end
      if (hit) begin
         done_in = 1'b1;
      end
      if (is_data && req_tlast) begin
         pos_in  = '0;
         done_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (hit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         rsp_data_in[0]     = 1'b1;
         rsp_data_in[13:1]  = start_full[START_W-1:0];
         rsp_data_in[14]    = has_cap_ff;
         rsp_data_in[28:15] = has_cap_ff ? cap_full[CAPPOS_W-1:0] : '0;
      end else if (is_data && req_tlast && !done_ff) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= LENGTH_W'(1);
         pos_ff       <= '0;
         done_ff      <= 1'b0;
         settle_ff    <= SETTLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            len_ff <= csr_wdata;
         end
         pos_ff       <= pos_in;
         done_ff      <= done_in;
         settle_ff    <= settle_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lastx_ff    <= lastx_in;
      cap_ff      <= cap_in;
      has_cap_ff  <= has_cap_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for masked_byte_pattern_scanner_core with pattern loads and block scans.
module tb;
   import mbps_pkg::*;

   localparam int ELEMS         = MAX_ELEMENTS_DEF;
   localparam int SCAN_LIMIT    = SCAN_BYTES_DEF;
   localparam int TAIL_LIMIT    = SCAN_BYTES_DEF + TAIL_BYTES_DEF;
   localparam int SETTLE_CYCLES = ELEMS + 16;
   localparam int IDLE_LIMIT    = 4000;
   localparam int RANDOM_ITEMS  = 1400;

   localparam logic [KIND_W-1:0] KIND_WILDCARD = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SPARE    = 2'd3;

   typedef enum logic [1:0] {ACT_SEND, ACT_CSR, ACT_DRAIN} stim_act_type;
   typedef enum logic [1:0] {RX_OPEN, RX_CHOPPY, RX_BLOCKED} rx_mode_type;

   typedef struct packed {
      logic              req_type;
      logic [INDEX_W-1:0] elem_index;
      logic [BYTE_W-1:0] elem_byte;
      logic [KIND_W-1:0] elem_kind;
      logic [BYTE_W-1:0] data_byte;
      logic              last;
   } scan_item_type;

   typedef struct packed {
      logic                found;
      logic [START_W-1:0]  start;
      logic                cap_valid;
      logic [CAPPOS_W-1:0] cap_pos;
   } scan_result_type;

   typedef struct {
      stim_act_type       act;
      scan_item_type      item;
      logic [LENGTH_W-1:0] csr_val;
   } stim_entry_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [LENGTH_W-1:0]   csr_wdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   stim_entry_type  stim_q[$];
   scan_result_type match_q[$];

   // scanner shadow state
   logic [BYTE_W-1:0]   pat_byte [ELEMS];
   logic [KIND_W-1:0]   pat_kind [ELEMS];
   logic [ELEMS-1:0]    partial_hits = '0;
   int                  scan_pos = 0;
   logic                block_hit = 1'b0;
   logic [LENGTH_W-1:0] pat_len = 7'd1;

   // pattern as the stimulus builder last wrote it
   logic [BYTE_W-1:0] gen_byte [ELEMS];
   logic [KIND_W-1:0] gen_kind [ELEMS];
   int                gen_len = 1;

   int n_items = 0, n_loads = 0, n_bytes = 0, n_csr = 0;
   int n_accepted = 0, n_results = 0, n_found = 0, n_errors = 0;
   int burst_left = 1, gap_left = 0, settle_cnt = 0;
   int stall_left = 0, mode_left = 0, idle_cycles = 0;
   rx_mode_type   rx_mode = RX_OPEN;
   scan_item_type sent_item;
   logic          next_valid, next_we;

   masked_byte_pattern_scanner_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic scan_step(input scan_item_type it);
      int used, first_x, last_x, cap_x, n, start;
      logic hit, ok;
      scan_result_type res;
      if (it.req_type == REQ_LOAD) begin
         pat_byte[it.elem_index] = it.elem_byte;
         pat_kind[it.elem_index] = it.elem_kind;
         return;
      end
      used = (pat_len > ELEMS) ? ELEMS : int'(pat_len);
      first_x = used;
      last_x = 0;
      cap_x = used;
      hit = 1'b0;
      start = 0;
      for (n = 0; n < used; n++) begin
         if (pat_kind[n] == KIND_EXACT) begin
            if (first_x == used) first_x = n;
            last_x = n;
         end
         if (pat_kind[n] == KIND_CAPTURE && cap_x == used) cap_x = n;
      end
      if (!block_hit) begin
         if (scan_pos >= TAIL_LIMIT) begin
            partial_hits = '0;
         end else begin
            if (first_x < used) begin
               for (n = last_x; n > first_x; n--) begin
                  ok = pat_kind[n] != KIND_EXACT || pat_byte[n] == it.data_byte;
                  partial_hits[n] = partial_hits[n-1] && ok;
               end
               partial_hits[first_x] = scan_pos < SCAN_LIMIT &&
                                       pat_byte[first_x] == it.data_byte;
               if (partial_hits[last_x]) begin
                  hit = 1'b1;
                  start = scan_pos - last_x;
               end
            end
            scan_pos++;
         end
      end
      res = '0;
      if (hit) begin
         res.found = 1'b1;
         res.start = START_W'(start);
         res.cap_valid = cap_x < used;
         res.cap_pos = (cap_x < used) ? CAPPOS_W'(start + cap_x) : '0;
         match_q.push_back(res);
         block_hit = 1'b1;
      end else if (it.last && !block_hit) begin
         match_q.push_back(res);
      end
      if (it.last) begin
         partial_hits = '0;
         scan_pos = 0;
         block_hit = 1'b0;
      end
   endtask

   function automatic logic [KIND_W-1:0] pick_kind();
      int r;
      r = $urandom_range(0, 9);
      if (r < 5) return KIND_EXACT;
      if (r < 7) return KIND_WILDCARD;
      if (r < 9) return KIND_CAPTURE;
      return KIND_SPARE;
   endfunction

   task automatic push_load(input int idx, input logic [BYTE_W-1:0] b,
                            input logic [KIND_W-1:0] k);
      stim_entry_type e;
      e.act = ACT_SEND;
      e.csr_val = '0;
      e.item.req_type = REQ_LOAD;
      e.item.elem_index = INDEX_W'(idx);
      e.item.elem_byte = b;
      e.item.elem_kind = k;
      e.item.data_byte = BYTE_W'($urandom);
      e.item.last = 1'($urandom_range(0, 1));
      gen_byte[idx] = b;
      gen_kind[idx] = k;
      stim_q.push_back(e);
      n_items++;
      n_loads++;
   endtask

   task automatic push_byte(input logic [BYTE_W-1:0] b, input logic last);
      stim_entry_type e;
      e.act = ACT_SEND;
      e.csr_val = '0;
      e.item.req_type = REQ_DATA;
      e.item.elem_index = INDEX_W'($urandom);
      e.item.elem_byte = BYTE_W'($urandom);
      e.item.elem_kind = KIND_W'($urandom);
      e.item.data_byte = b;
      e.item.last = last;
      stim_q.push_back(e);
      n_items++;
      n_bytes++;
   endtask

   // wait for the block to go idle, then write the length
   task automatic push_csr(input int len);
      stim_entry_type e;
      e.item = '0;
      e.csr_val = '0;
      e.act = ACT_DRAIN;
      stim_q.push_back(e);
      e.act = ACT_CSR;
      e.csr_val = LENGTH_W'(len);
      stim_q.push_back(e);
      gen_len = len;
      n_csr++;
   endtask

   task automatic add_block(input int blk_len, input logic plant);
      logic [BYTE_W-1:0] blk_q[$];
      int used, first_x, anchor, n, pos;
      used = (gen_len > ELEMS) ? ELEMS : gen_len;
      for (n = 0; n < blk_len; n++) begin
         if ($urandom_range(0, 1) == 0 || used == 0) blk_q.push_back(BYTE_W'($urandom));
         else blk_q.push_back(gen_byte[$urandom_range(0, used - 1)]);
      end
      first_x = used;
      for (n = used - 1; n >= 0; n--) if (gen_kind[n] == KIND_EXACT) first_x = n;
      if (plant && first_x < used) begin
         anchor = $urandom_range(0, blk_len - 1);
         for (n = first_x; n < used; n++) begin
            pos = anchor - first_x + n;
            if (gen_kind[n] == KIND_EXACT && pos < blk_len) blk_q[pos] = gen_byte[n];
         end
      end
      for (n = 0; n < blk_len; n++) begin
         if (n > 0 && $urandom_range(0, 49) == 0)
            push_load($urandom_range(0, ELEMS - 1), BYTE_W'($urandom), pick_kind());
         push_byte(blk_q[n], n == blk_len - 1);
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         csr_we <= 1'b0;
      end else begin
         next_valid = req_tvalid && !req_tready;
         next_we = 1'b0;
         if (req_tvalid && req_tready) begin
            scan_step(sent_item);
            n_accepted++;
         end
         if (!next_valid && stim_q.size() != 0) begin
            case (stim_q[0].act)
               ACT_DRAIN: begin
                  if (match_q.size() != 0) begin
                     settle_cnt = 0;
                  end else if (settle_cnt < SETTLE_CYCLES) begin
                     settle_cnt++;
                  end else begin
                     settle_cnt = 0;
                     stim_q.delete(0);
                  end
               end
               ACT_CSR: begin
                  next_we = 1'b1;
                  csr_wdata <= stim_q[0].csr_val;
                  pat_len = stim_q[0].csr_val;
                  stim_q.delete(0);
               end
               default: begin
                  if (gap_left > 0) begin
                     gap_left--;
                  end else begin
                     sent_item = stim_q[0].item;
                     stim_q.delete(0);
                     req_tdata <= {sent_item.data_byte, sent_item.elem_kind,
                                   sent_item.elem_byte, sent_item.elem_index};
                     req_tuser <= sent_item.req_type;
                     req_tlast <= sent_item.last;
                     next_valid = 1'b1;
                     burst_left--;
                     if (burst_left <= 0) begin
                        burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                                : $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                     end
                  end
               end
            endcase
         end
         req_tvalid <= next_valid;
         csr_we <= next_we;
      end
   end

   // monitor and result check
   always @(posedge clock) begin
      scan_result_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.found = rsp_tdata[0];
            got.start = rsp_tdata[13:1];
            got.cap_valid = rsp_tdata[14];
            got.cap_pos = rsp_tdata[28:15];
            if (match_q.size() == 0) begin
               $error("unexpected result, rsp_tdata %h", rsp_tdata);
               n_errors++;
            end else begin
               want = match_q.pop_front();
               n_results++;
               if (want.found) n_found++;
               if (got.found !== want.found) begin
                  $error("found: expected %0d, got %0d", want.found, got.found);
                  n_errors++;
               end
               if (got.start !== want.start) begin
                  $error("match_start: expected %0d, got %0d",
                         $signed(want.start), $signed(got.start));
                  n_errors++;
               end
               if (got.cap_valid !== want.cap_valid) begin
                  $error("capture_valid: expected %0d, got %0d",
                         want.cap_valid, got.cap_valid);
                  n_errors++;
               end
               if (got.cap_pos !== want.cap_pos) begin
                  $error("capture_pos: expected %0d, got %0d",
                         $signed(want.cap_pos), $signed(got.cap_pos));
                  n_errors++;
               end
            end
         end
         if (mode_left == 0) begin
            rx_mode = rx_mode_type'($urandom_range(0, 2));
            mode_left = $urandom_range(50, 400);
         end else begin
            mode_left--;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if ((rx_mode == RX_CHOPPY && $urandom_range(0, 99) < 30) ||
                      (rx_mode == RX_BLOCKED && $urandom_range(0, 99) < 5)) begin
            stall_left = (rx_mode == RX_CHOPPY) ? $urandom_range(0, 2) : $urandom_range(5, 30);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int n, k, len, cnt, used, goal;
      for (n = 0; n < ELEMS; n++) push_load(n, BYTE_W'($urandom), pick_kind());

      push_load(0, 8'h5A, KIND_WILDCARD);
      push_load(1, 8'hC3, KIND_CAPTURE);
      push_load(2, 8'hFF, KIND_EXACT);
      push_load(3, 8'h00, KIND_SPARE);
      push_load(4, 8'h00, KIND_EXACT);
      push_csr(5);
      // leading wildcards fall before the block; the byte after the match is dropped
      push_byte(8'hFF, 1'b0);
      push_byte(8'h11, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'h33, 1'b1);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h01, 1'b1);
      // rewrite an element while the block is open
      push_byte(8'hFF, 1'b0);
      push_load(4, 8'h77, KIND_EXACT);
      push_byte(8'h22, 1'b0);
      push_byte(8'h77, 1'b1);
      push_csr(0);
      push_byte(8'hFF, 1'b1);
      push_csr(2);
      push_byte(8'hFF, 1'b1);
      push_csr(127);
      push_byte(8'h00, 1'b1);
      push_load(63, 8'hFF, KIND_SPARE);
      push_load(0, 8'h00, KIND_EXACT);
      push_csr(1);
      push_byte(8'h00, 1'b1);

      goal = n_items + RANDOM_ITEMS;
      while (n_items < goal) begin
         k = $urandom_range(0, 15);
         if (k == 0) len = 0;
         else if (k == 1) len = 127;
         else if (k == 2) len = 64;
         else if (k == 3) len = $urandom_range(65, 126);
         else if (k < 8) len = $urandom_range(1, 64);
         else len = $urandom_range(1, 8);
         push_csr(len);
         used = (len > ELEMS) ? ELEMS : len;
         cnt = $urandom_range(0, 6);
         for (n = 0; n < cnt; n++) begin
            if (used > 0 && $urandom_range(0, 3) != 0)
               push_load($urandom_range(0, used - 1), BYTE_W'($urandom), pick_kind());
            else
               push_load($urandom_range(0, ELEMS - 1), BYTE_W'($urandom), pick_kind());
         end
         cnt = $urandom_range(1, 6);
         for (n = 0; n < cnt; n++)
            add_block(($urandom_range(0, 9) == 0) ? $urandom_range(49, 200)
                                                 : $urandom_range(1, 48),
                      $urandom_range(0, 3) != 0);
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      while (stim_q.size() != 0 || n_accepted != n_items) @(posedge clock);
      while (match_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("Scanned %0d data bytes with %0d pattern loads over %0d length settings",
               n_bytes, n_loads, n_csr);
      $display("Checked %0d block results, %0d of them matches", n_results, n_found);
      if (n_errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
